>>> hw/rtl/dpll_sat_with_cardinality_macros.svh
// assertion macros shared by the solver rtl
// expects signals named clock and reset in the including module
`ifndef DPLL_SAT_WITH_CARDINALITY_MACROS_SVH
`define DPLL_SAT_WITH_CARDINALITY_MACROS_SVH

// condition holds at every edge outside reset
`define DSAT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define DSAT_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/dsat_pkg.sv
// shared types, codes and a helper function of the dpll solver
// no dependencies
package dsat_pkg;

   localparam int VAR_W    = 64;
   localparam int VIDX_W   = 6;
   localparam int VCNT_W   = 7;
   localparam int VAR_MAX  = 64;
   localparam int DEF_MAX_CLAUSES = 256;

   localparam logic [1:0] CMD_CLAUSE = 2'd0;
   localparam logic [1:0] CMD_ASSUME = 2'd1;
   localparam logic [1:0] CMD_SOLVE  = 2'd2;

   localparam logic [2:0] ST_SAT   = 3'd0;
   localparam logic [2:0] ST_UNSAT = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_COUNT = 3'd4;

   typedef struct packed {
      logic [VAR_W-1:0] neg;
      logic [VAR_W-1:0] pos;
   } clause_type;

   // index of the lowest set bit, zero for an empty word
   function automatic logic [VIDX_W-1:0] lowest_bit(input logic [VAR_W-1:0] x);
      logic [VAR_W-1:0]  iso;
      logic [VIDX_W-1:0] idx;
      iso = x & (~x + 64'd1);
      idx = '0;
      for (int i = 0; i < VAR_W; i++) begin
         if (iso[i]) begin
            idx = idx | VIDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> hw/rtl/dpll_sat_with_cardinality.sv
// dpll sat solver with exactly-k true count rule, top level
// depends on dsat_pkg, dsat_clause_mem and the assertion macro header
//
// channel  dir  signals                      contents
// req      in   tvalid tready tdata tuser tlast   literal, assumption or solve
// rsp      out  tvalid tready tdata tuser          status and model
// csr      in   we wdata                            var_count
//
// loading items are taken one per cycle while no result waits; a solve runs a
// data-dependent search on one shared clause evaluator, ready low: each clause
// visit reads then evaluates, queued assignments one per cycle, an undone
// trail entry passes check and clear states; reset is synchronous and needs
// no clearing pass: clause, trail and decision stores are read only where
// written; a waiting result holds req_tready low until rsp_tready takes it
`include "dpll_sat_with_cardinality_macros.svh"

module dpll_sat_with_cardinality #(
   parameter int MAX_CLAUSES = dsat_pkg::DEF_MAX_CLAUSES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // literal_var[6:0], literal_positive[7],
                                    // count_limited[8], required count[15:9]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        req_tlast,   // clause_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // model[63:0]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // var_count
);
   import dsat_pkg::*;

   localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int HW = $clog2(MAX_CLAUSES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ASSUME, S_CARD, S_FORCE, S_CL_RD, S_CL_EV, S_DECIDE,
      S_BT, S_BT_TOP, S_UNDO, S_UNDO_EV, S_FLIP
   } state_type;

   state_type          state_ff, state_in;
   logic [VCNT_W-1:0]  var_count_ff, var_count_in;
   logic [VAR_W-1:0]   build_pos_ff, build_pos_in, build_neg_ff, build_neg_in;
   logic               build_skip_ff, build_skip_in;
   logic [VAR_W-1:0]   assume_pos_ff, assume_pos_in, assume_neg_ff, assume_neg_in;
   logic [HW-1:0]      held_ff, held_in;
   logic [VAR_W-1:0]   asg_ff, asg_in, val_ff, val_in;
   logic [VCNT_W-1:0]  trail_len_ff, trail_len_in, depth_ff, depth_in;
   logic [VCNT_W-1:0]  n_asg_ff, n_asg_in, n_true_ff, n_true_in;
   logic               limited_ff, limited_in;
   logic [VCNT_W-1:0]  k_ff, k_in;
   logic [VAR_W-1:0]   vm_ff, vm_in, work_ff, work_in, ap_ff, ap_in;
   logic               force_val_ff, force_val_in, changed_ff, changed_in;
   logic [HW-1:0]      cl_idx_ff, cl_idx_in;
   logic [7:0]         top_ff, top_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [VAR_W-1:0]   rsp_model_ff, rsp_model_in;

   // request fields
   logic [1:0]        f_cmd;
   logic [6:0]        f_var;
   logic              f_pos, f_end, f_lim;
   logic [6:0]        f_k;
   logic              accept, in_range, solve_go;
   logic [VAR_W-1:0]  lit_bit, vm_now, ap_now, an_now, bp, bn;

   // assignment and undo controls
   logic              set_en, set_val, clr_en;
   logic [VIDX_W-1:0] set_idx, clr_idx;

   // trail and decision stack
   logic [VIDX_W-1:0] trail_mem [VAR_W];
   logic [7:0]        stack_mem [VAR_W];
   logic [VIDX_W-1:0] trail_rd_ff, trail_raddr;
   logic [7:0]        stack_rd_ff, stack_wdata;
   logic              stack_we;
   logic [VIDX_W-1:0] stack_waddr, stack_raddr;

   // clause store
   logic              cm_we;
   clause_type        cm_wdata, cm_rdata;
   logic [AW-1:0]     cm_raddr;

   // evaluation terms
   logic [VCNT_W-1:0] open_cnt;
   logic [VCNT_W:0]   reach;
   logic [VAR_W-1:0]  free_v, cp, cn, c_open;
   logic              c_sat, c_single, c_last;

   assign f_cmd = req_tuser;
   assign f_var = req_tdata[6:0];
   assign f_pos = req_tdata[7];
   assign f_lim = req_tdata[8];
   assign f_k   = req_tdata[15:9];
   assign f_end = req_tlast;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (f_var != 7'd0) && (f_var <= var_count_ff);
   assign lit_bit    = 64'd1 << (f_var - 7'd1);
   assign vm_now     = (var_count_ff >= 7'(VAR_MAX)) ? '1 :
                       ((64'd1 << var_count_ff) - 64'd1);
   assign ap_now     = assume_pos_ff & vm_now;
   assign an_now     = assume_neg_ff & vm_now;

   // solve accepted that goes on to search
   assign solve_go = accept && (f_cmd == CMD_SOLVE) && !(f_lim && f_k > var_count_ff) &&
                     ((ap_now & an_now) == '0);

   assign open_cnt = var_count_ff - n_asg_ff;
   assign reach    = {1'b0, n_true_ff} + {1'b0, open_cnt};
   assign free_v   = ~asg_ff & vm_ff;
   assign cp       = cm_rdata.pos & vm_ff;
   assign cn       = cm_rdata.neg & vm_ff;
   assign c_sat    = |((cp & asg_ff & val_ff) | (cn & asg_ff & ~val_ff));
   assign c_open   = (cp | cn) & ~asg_ff;
   assign c_single = ((c_open & (c_open - 64'd1)) == '0);
   assign c_last   = (HW'(cl_idx_ff + 1'b1) == held_ff);

   assign cm_raddr    = cl_idx_ff[AW-1:0];
   assign stack_raddr = VIDX_W'(depth_ff - 7'd1);

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      var_count_in  = var_count_ff;
      build_pos_in  = build_pos_ff;
      build_neg_in  = build_neg_ff;
      build_skip_in = build_skip_ff;
      assume_pos_in = assume_pos_ff;
      assume_neg_in = assume_neg_ff;
      held_in       = held_ff;
      asg_in        = asg_ff;
      val_in        = val_ff;
      trail_len_in  = trail_len_ff;
      depth_in      = depth_ff;
      n_asg_in      = n_asg_ff;
      n_true_in     = n_true_ff;
      limited_in    = limited_ff;
      k_in          = k_ff;
      vm_in         = vm_ff;
      work_in       = work_ff;
      ap_in         = ap_ff;
      force_val_in  = force_val_ff;
      changed_in    = changed_ff;
      cl_idx_in     = cl_idx_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_model_in  = rsp_model_ff;
      set_en        = 1'b0;
      set_val       = 1'b0;
      set_idx       = '0;
      clr_en        = 1'b0;
      clr_idx       = trail_rd_ff;
      trail_raddr   = VIDX_W'(trail_len_ff - 7'd1);
      stack_we      = 1'b0;
      stack_waddr   = stack_raddr;
      stack_wdata   = '0;
      cm_we         = 1'b0;
      cm_wdata.pos  = build_pos_ff;
      cm_wdata.neg  = build_neg_ff;
      bp            = build_pos_ff;
      bn            = build_neg_ff;

      // register write, clamped to the range 1 to VAR_MAX
      if (csr_we) begin
         if (csr_wdata == 7'd0) begin
            var_count_in = 7'd1;
         end else if (csr_wdata > 7'(VAR_MAX)) begin
            var_count_in = 7'(VAR_MAX);
         end else begin
            var_count_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (f_cmd)
                  CMD_CLAUSE: begin
                     if (build_skip_ff) begin
                        if (f_end) build_skip_in = 1'b0;
                     end else if (!in_range && !(f_var == 7'd0 && f_end)) begin
                        build_pos_in  = '0;
                        build_neg_in  = '0;
                        build_skip_in = !f_end;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                        rsp_model_in  = '0;
                     end else begin
                        if (f_var != 7'd0) begin
                           if (f_pos) bp = build_pos_ff | lit_bit;
                           else       bn = build_neg_ff | lit_bit;
                        end
                        build_pos_in = bp;
                        build_neg_in = bn;
                        cm_wdata.pos = bp;
                        cm_wdata.neg = bn;
                        if (f_end) begin
                           build_pos_in = '0;
                           build_neg_in = '0;
                           if ((bp & bn) == '0) begin
                              if (held_ff >= HW'(MAX_CLAUSES)) begin
                                 rsp_valid_in  = 1'b1;
                                 rsp_status_in = ST_FULL;
                                 rsp_model_in  = '0;
                              end else begin
                                 cm_we   = 1'b1;
                                 held_in = held_ff + 1'b1;
                              end
                           end
                        end
                     end
                  end
                  CMD_ASSUME: begin
                     if (!in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                        rsp_model_in  = '0;
                     end else if (f_pos) begin
                        assume_pos_in = assume_pos_ff | lit_bit;
                     end else begin
                        assume_neg_in = assume_neg_ff | lit_bit;
                     end
                  end
                  CMD_SOLVE: begin
                     assume_pos_in = '0;
                     assume_neg_in = '0;
                     asg_in        = '0;
                     val_in        = '0;
                     trail_len_in  = '0;
                     depth_in      = '0;
                     n_asg_in      = '0;
                     n_true_in     = '0;
                     limited_in    = f_lim;
                     k_in          = f_k;
                     vm_in         = vm_now;
                     ap_in         = ap_now;
                     work_in       = ap_now | an_now;
                     rsp_model_in  = '0;
                     if (f_lim && f_k > var_count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_COUNT;
                     end else if ((ap_now & an_now) != '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_UNSAT;
                     end else if ((ap_now | an_now) != '0) begin
                        state_in = S_ASSUME;
                     end else begin
                        state_in = S_CARD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // queued assumptions, one per cycle
         S_ASSUME: begin
            set_en  = 1'b1;
            set_idx = lowest_bit(work_ff);
            set_val = ap_ff[set_idx];
            work_in = work_ff & (work_ff - 64'd1);
            if (work_in == '0) state_in = S_CARD;
         end

         // exactly-k check on the running counts
         S_CARD: begin
            changed_in = 1'b0;
            cl_idx_in  = '0;
            if (limited_ff && (n_true_ff > k_ff || reach < {1'b0, k_ff})) begin
               state_in = S_BT;
            end else if (limited_ff && open_cnt != '0 &&
                         (n_true_ff == k_ff || reach == {1'b0, k_ff})) begin
               work_in      = free_v;
               force_val_in = (reach == {1'b0, k_ff});
               changed_in   = 1'b1;
               state_in     = S_FORCE;
            end else if (held_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_CL_RD;
            end
         end

         // forced assignments from the count rule
         S_FORCE: begin
            set_en  = 1'b1;
            set_idx = lowest_bit(work_ff);
            set_val = force_val_ff;
            work_in = work_ff & (work_ff - 64'd1);
            if (work_in == '0) begin
               state_in = (held_ff == '0) ? S_CARD : S_CL_RD;
            end
         end

         S_CL_RD: begin
            state_in = S_CL_EV;
         end

         // unit rule on one stored clause
         S_CL_EV: begin
            if (!c_sat && c_open == '0) begin
               state_in = S_BT;
            end else begin
               if (!c_sat && c_single) begin
                  set_en     = 1'b1;
                  set_idx    = lowest_bit(c_open);
                  set_val    = |(cp & c_open);
                  changed_in = 1'b1;
               end
               if (c_last) begin
                  state_in = changed_in ? S_CARD : S_DECIDE;
               end else begin
                  cl_idx_in = cl_idx_ff + 1'b1;
                  state_in  = S_CL_RD;
               end
            end
         end

         // branch on the lowest free variable, true first; sat once none is free
         S_DECIDE: begin
            if (free_v == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SAT;
               rsp_model_in  = val_ff & asg_ff & vm_ff;
               state_in      = S_IDLE;
            end else begin
               stack_we    = 1'b1;
               stack_waddr = VIDX_W'(depth_ff);
               stack_wdata = {1'b1, trail_len_ff};
               depth_in    = depth_ff + 1'b1;
               set_en      = 1'b1;
               set_idx     = lowest_bit(free_v);
               set_val     = 1'b1;
               state_in    = S_CARD;
            end
         end

         // conflict: pop to the last open decision, unsat when none is left
         S_BT: begin
            if (depth_ff == '0) begin
               asg_in        = '0;
               val_in        = '0;
               trail_len_in  = '0;
               n_asg_in      = '0;
               n_true_in     = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_UNSAT;
               rsp_model_in  = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_BT_TOP;
            end
         end

         S_BT_TOP: begin
            top_in   = stack_rd_ff;
            state_in = S_UNDO;
         end

         S_UNDO: begin
            if (trail_len_ff > top_ff[6:0]) begin
               state_in = S_UNDO_EV;
            end else begin
               trail_raddr = VIDX_W'(top_ff[6:0]);
               state_in    = S_FLIP;
            end
         end

         S_UNDO_EV: begin
            clr_en   = 1'b1;
            state_in = S_UNDO;
         end

         // retry the decision false, or drop it
         S_FLIP: begin
            if (top_ff[7]) begin
               stack_we    = 1'b1;
               stack_wdata = {1'b0, top_ff[6:0]};
               set_en      = 1'b1;
               set_idx     = trail_rd_ff;
               set_val     = 1'b0;
               state_in    = S_CARD;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = S_BT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // apply one assignment or one undo
      if (set_en) begin
         asg_in[set_idx] = 1'b1;
         val_in[set_idx] = set_val;
         trail_len_in    = trail_len_ff + 1'b1;
         n_asg_in        = n_asg_ff + 1'b1;
         n_true_in       = n_true_ff + VCNT_W'(set_val);
      end else if (clr_en) begin
         asg_in[clr_idx] = 1'b0;
         val_in[clr_idx] = 1'b0;
         trail_len_in    = trail_len_ff - 1'b1;
         n_asg_in        = n_asg_ff - 1'b1;
         n_true_in       = n_true_ff - VCNT_W'(val_ff[clr_idx]);
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         var_count_ff  <= 7'(VAR_MAX);
         build_pos_ff  <= '0;
         build_neg_ff  <= '0;
         build_skip_ff <= 1'b0;
         assume_pos_ff <= '0;
         assume_neg_ff <= '0;
         held_ff       <= '0;
         asg_ff        <= '0;
         val_ff        <= '0;
         trail_len_ff  <= '0;
         depth_ff      <= '0;
         n_asg_ff      <= '0;
         n_true_ff     <= '0;
         changed_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         var_count_ff  <= var_count_in;
         build_pos_ff  <= build_pos_in;
         build_neg_ff  <= build_neg_in;
         build_skip_ff <= build_skip_in;
         assume_pos_ff <= assume_pos_in;
         assume_neg_ff <= assume_neg_in;
         held_ff       <= held_in;
         asg_ff        <= asg_in;
         val_ff        <= val_in;
         trail_len_ff  <= trail_len_in;
         depth_ff      <= depth_in;
         n_asg_ff      <= n_asg_in;
         n_true_ff     <= n_true_in;
         changed_ff    <= changed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      limited_ff    <= limited_in;
      k_ff          <= k_in;
      vm_ff         <= vm_in;
      work_ff       <= work_in;
      ap_ff         <= ap_in;
      force_val_ff  <= force_val_in;
      cl_idx_ff     <= cl_idx_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_model_ff  <= rsp_model_in;
   end

   // trail store
   always_ff @(posedge clock) begin
      if (set_en) begin
         trail_mem[trail_len_ff[VIDX_W-1:0]] <= set_idx;
      end
      trail_rd_ff <= trail_mem[trail_raddr];
   end

   // decision stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   dsat_clause_mem #(
      .DEPTH (MAX_CLAUSES),
      .AW    (AW)
   ) u_clause_mem (
      .clock (clock),
      .we    (cm_we),
      .waddr (held_ff[AW-1:0]),
      .wdata (cm_wdata),
      .raddr (cm_raddr),
      .rdata (cm_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_model_ff;

   // invariants of the search state
   // while a decision is being undone its own trail entry may already be gone
   `DSAT_ASSERT_ALWAYS(a_count_trail, n_asg_ff == trail_len_ff, "assigned count off trail")
   `DSAT_ASSERT_ALWAYS(a_true_le_asg, n_true_ff <= n_asg_ff, "true count above assigned")
   `DSAT_ASSERT_ALWAYS(a_depth_le_trail, {1'b0, depth_ff} <= ({1'b0, trail_len_ff} + 8'd1), "decisions exceed trail")
   `DSAT_ASSERT_ALWAYS(a_busy_stall, (state_ff == S_IDLE) || !req_tready, "ready while busy")
   `DSAT_ASSERT_NEXT(a_solve_busy, solve_go, !req_tready, "solve did not start")

endmodule

>>> hw/rtl/dsat_clause_mem.sv
// clause store: one write port, one registered read port
// depends on dsat_pkg for the clause type
module dsat_clause_mem #(
   parameter int DEPTH = dsat_pkg::DEF_MAX_CLAUSES,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  dsat_pkg::clause_type wdata,
   input  logic [AW-1:0]        raddr,
   output dsat_pkg::clause_type rdata
);
   import dsat_pkg::*;

   clause_type mem [DEPTH];
   clause_type rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
